/* hdl/mglf_pkg.sv */
// ----------------------------------------------------------------------------
// mglf_pkg
// Shared constants for the mask-guided line fill block.
// ----------------------------------------------------------------------------
package mglf_pkg;

  // Width of the line_width configuration register.
  localparam int unsigned LineWidthBits = 13;

  // Parameter defaults.
  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned PixelBitsDef = 24;

  // Reset value of line_width.
  localparam logic [LineWidthBits-1:0] LineWidthRst = 13'd4096;

endpackage

/* hdl/mask_guided_line_fill_top.sv */
// ----------------------------------------------------------------------------
// mask_guided_line_fill_top
// Streaming vertical-then-horizontal fill of masked line regions.
// ----------------------------------------------------------------------------
// Usage notes:
// - Input channel (in_valid_i/in_ready_o) takes one raster pixel per transfer
//   with its vertical mask, horizontal mask and frame start flag.
// - Output channel (out_valid_o/out_ready_i) gives one filled pixel per input
//   transfer, plus row_end on the last pixel of each row.
// - Config channel (cfg_valid_i/cfg_ready_o) writes line_width; always ready.
//   Only write it while the block is idle.
// - Throughput is one pixel per clock while the receiver keeps up. The line
//   memory read is registered at the input transfer, and the fill logic loads
//   the output register when the internal stage moves on, so a pixel passes
//   the internal stage and the output register before its output transfer.
// - All per-column state (previous row pixel, its vertical mask and the
//   column fill value) lives in one line memory read at accept and written
//   back on leaving the fill stage; a same-column read/write overlap is forwarded.
// - The column fill store is "cleared" by a fill count of columns visited in
//   the current frame, so no clearing sweep is needed after reset.
// - Reset clears column, first-row and horizontal fill state; a stream
//   without a frame start behaves as if a frame began at reset.
// - A stalled receiver holds the output register; the block keeps taking
//   input until the internal stage is also full.
// ----------------------------------------------------------------------------
module mask_guided_line_fill_top
  import mglf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned PIXEL_BITS = PixelBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [LineWidthBits-1:0] cfg_line_width_i,
  // input pixels
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [PIXEL_BITS-1:0]    pixel_in_i,
  input  logic                     vert_mask_i,
  input  logic                     horiz_mask_i,
  input  logic                     frame_start_i,
  // output pixels
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [PIXEL_BITS-1:0]    pixel_out_o,
  output logic                     row_end_o
);

  localparam int unsigned IdxW  = $clog2(MAX_WIDTH);
  localparam int unsigned CntW  = $clog2(MAX_WIDTH + 1);
  // common width for width comparisons
  localparam int unsigned EffW  = (LineWidthBits > CntW) ? LineWidthBits : CntW;
  localparam int unsigned EntW  = 2 * PIXEL_BITS + 1;

  localparam logic [EffW-1:0] MaxW = EffW'(MAX_WIDTH);
  localparam logic [EffW-1:0] OneW = EffW'(1);

  // Item held between memory read and fill logic.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic                  vm;
    logic                  hm;
    logic                  fs;       // frame start
    logic                  fr;       // first row
    logic [IdxW-1:0]       col;
    logic                  cf_ok;    // column fill written this frame
    logic                  fwd;      // read overlapped previous write
    logic                  last;
  } s1_t;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [LineWidthBits-1:0] line_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LineWidthRst;
    end else if (cfg_valid_i) begin
      line_width_q <= cfg_line_width_i;
    end
  end

  // Effective width: zero counts as one, clamp to the line memory depth.
  logic [EffW-1:0] lw_ext, eff_width;

  always_comb begin
    lw_ext = EffW'(line_width_q);
    if (lw_ext == '0) begin
      eff_width = OneW;
    end else if (lw_ext > MaxW) begin
      eff_width = MaxW;
    end else begin
      eff_width = lw_ext;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic s1_valid_q, out_valid_q;
  logic s1_fire, in_fire;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Accept stage: column tracking and memory read
  // --------------------------------------------------------------------------
  logic [IdxW-1:0] col_q, col0;
  logic            first_row_q, fr0;
  logic [CntW-1:0] visited_q, vis0;
  logic            cf_ok0, last0, fwd0;
  s1_t             s1_q;

  always_comb begin
    col0   = frame_start_i ? '0 : col_q;
    fr0    = frame_start_i | first_row_q;
    vis0   = frame_start_i ? '0 : visited_q;
    // columns below the fill count were written since frame start
    cf_ok0 = CntW'(col0) < vis0;
    last0  = (EffW'(col0) + OneW) >= eff_width;
    fwd0   = s1_fire && (s1_q.col == col0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
      visited_q   <= '0;
    end else if (in_fire) begin
      col_q       <= last0 ? '0 : col0 + IdxW'(1);
      first_row_q <= last0 ? 1'b0 : fr0;
      visited_q   <= (CntW'(col0) == vis0) ? vis0 + CntW'(1) : vis0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.pix   <= pixel_in_i;
      s1_q.vm    <= vert_mask_i;
      s1_q.hm    <= horiz_mask_i;
      s1_q.fs    <= frame_start_i;
      s1_q.fr    <= fr0;
      s1_q.col   <= col0;
      s1_q.cf_ok <= cf_ok0;
      s1_q.fwd   <= fwd0;
      s1_q.last  <= last0;
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: {above pixel, above vertical mask, column fill}
  // --------------------------------------------------------------------------
  logic [EntW-1:0] rd_entry, wr_entry, fwd_entry_q;

  mglf_ram #(
    .Depth (MAX_WIDTH),
    .DataW (EntW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_q.col),
    .wdata_i (wr_entry),
    .re_i    (in_fire),
    .raddr_i (col0),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      fwd_entry_q <= wr_entry;
    end
  end

  // --------------------------------------------------------------------------
  // Fill stage
  // --------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] left_pix_q, row_fill_q;
  logic                  left_hm_q;

  logic [EntW-1:0]       entry;
  logic [PIXEL_BITS-1:0] above_pix, cf_mem, cf_old, cf_new, vpix;
  logic                  above_vm, vfill;
  logic [PIXEL_BITS-1:0] lpix, rfill, rf_new, hpix;
  logic                  lhm;

  always_comb begin
    entry     = s1_q.fwd ? fwd_entry_q : rd_entry;
    above_pix = entry[EntW-1 -: PIXEL_BITS];
    above_vm  = entry[PIXEL_BITS];
    cf_mem    = entry[PIXEL_BITS-1:0];
    cf_old    = s1_q.cf_ok ? cf_mem : '0;

    // vertical pass
    vfill  = !s1_q.fr && s1_q.vm;
    cf_new = (vfill && !above_vm) ? above_pix : cf_old;
    vpix   = vfill ? cf_new : s1_q.pix;

    // horizontal pass; frame start clears the running state
    lpix  = s1_q.fs ? '0 : left_pix_q;
    lhm   = s1_q.fs ? 1'b0 : left_hm_q;
    rfill = s1_q.fs ? '0 : row_fill_q;
    if ((s1_q.col != '0) && s1_q.hm) begin
      rf_new = lhm ? rfill : lpix;
      hpix   = rf_new;
    end else begin
      rf_new = rfill;
      hpix   = vpix;
    end

    wr_entry = {s1_q.pix, s1_q.vm, cf_new};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_pix_q <= '0;
      left_hm_q  <= 1'b0;
      row_fill_q <= '0;
    end else if (s1_fire) begin
      left_pix_q <= vpix;
      left_hm_q  <= s1_q.hm;
      row_fill_q <= rf_new;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] pixel_out_q;
  logic                  row_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      pixel_out_q <= hpix;
      row_end_q   <= s1_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign row_end_o   = row_end_q;

endmodule

/* hdl/mglf_ram.sv */
// ----------------------------------------------------------------------------
// mglf_ram
// Simple dual-port line memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mglf_ram
  import mglf_pkg::*;
#(
  parameter int unsigned Depth = MaxWidthDef,
  parameter int unsigned DataW = 2 * PixelBitsDef + 1,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
